>>> rtl/bssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bootload slave session control package
// Shared types, codes and constants for the session control block.
// ----------------------------------------------------------------------------
package bssc_pkg;

	localparam int UID_WIDTH   = 64;
	localparam int CFG_WIDTH   = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int SEQ_WIDTH   = 8;
	localparam int TICK_WIDTH  = 4;
	localparam int DATA_WIDTH  = 32;

	localparam logic [SEQ_WIDTH-1:0]  SEQ_STEP     = SEQ_WIDTH'(2);
	localparam logic [DATA_WIDTH-1:0] ADDR_CONTINUE = 32'hFFFF_FFFF;
	localparam logic [DATA_WIDTH-1:0] MODULE_ID_MASK = 32'h0000_00FF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OWN_UID      = 2'd0,
		REG_LOADING_MODE = 2'd1,
		REG_LINK_READY   = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		CMD_TICK       = 4'd0,
		CMD_ACK        = 4'd1,
		CMD_HEX_WRITE  = 4'd2,
		CMD_HEX_READ   = 4'd3,
		CMD_IDENTIFY   = 4'd4,
		CMD_SELECT     = 4'd5,
		CMD_DESELECT   = 4'd6,
		CMD_ERASE_CFG  = 4'd7,
		CMD_ERASE_USER = 4'd8,
		CMD_ERASE_PROG = 4'd9,
		CMD_CRC        = 4'd10,
		CMD_NAME       = 4'd11,
		CMD_ID         = 4'd12,
		CMD_BOOTLOAD   = 4'd13,
		CMD_RESET      = 4'd14,
		CMD_OTHER      = 4'd15
	} cmd_t;

	typedef enum logic [1:0] {
		HEX_BEGIN   = 2'd0,
		HEX_DATA    = 2'd1,
		HEX_END     = 2'd2,
		HEX_INVALID = 2'd3
	} hex_kind_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_ERROR        = 3'd1,
		ST_WRONG_SEQ    = 3'd2,
		ST_WRONG_UID    = 3'd3,
		ST_NOT_SELECTED = 3'd4,
		ST_BROKEN       = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		ACT_NONE        = 4'd0,
		ACT_ERASE_CFG   = 4'd1,
		ACT_ERASE_USER  = 4'd2,
		ACT_ERASE_PROG  = 4'd3,
		ACT_WRITE_CRC   = 4'd4,
		ACT_WRITE_NAME  = 4'd5,
		ACT_WRITE_ID    = 4'd6,
		ACT_RESET       = 4'd7,
		ACT_HEX_BEGIN   = 4'd8,
		ACT_HEX_DATA    = 4'd9,
		ACT_HEX_END     = 4'd10,
		ACT_READ_START  = 4'd11,
		ACT_READ_CONT   = 4'd12
	} action_t;

	typedef enum logic [2:0] {
		PAT_WAIT   = 3'd0,
		PAT_INIT   = 3'd1,
		PAT_LOAD   = 3'd2,
		PAT_MUTE   = 3'd3,
		PAT_IDENT  = 3'd4,
		PAT_SELECT = 3'd5
	} led_t;

	typedef struct packed {
		logic [3:0]            command;
		logic [SEQ_WIDTH-1:0]  sequence_req;
		logic [UID_WIDTH-1:0]  message_uid;
		logic [1:0]            hex_kind;
		logic [DATA_WIDTH-1:0] read_address;
		logic [DATA_WIDTH-1:0] payload;
		logic                  backend_ok;
	} msg_t;

	typedef struct packed {
		logic                  ack_valid;
		status_t               status;
		action_t               action;
		logic [DATA_WIDTH-1:0] payload_out;
		logic                  announce;
		led_t                  led_pattern;
	} result_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_WIDTH-1:0]  data;
	} cfg_wr_t;

endpackage
`default_nettype wire

>>> rtl/bootload_slave_session_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bootload slave session control
// Slave side of a bus bootloader session: message checks, acknowledge status,
// storage action requests, announce requests and LED pattern.
// ----------------------------------------------------------------------------
// Every input transaction gives exactly one result transaction. A message is
// registered at the input, evaluated against the session state and written
// to the result register, so a new message is accepted every cycle when
// out_ready is held high; otherwise the stages stall. The result is valid at
// the output from the result register and stays there until it is taken.
// The session state updates as each message leaves the input register, so
// back-to-back messages see each other's effect. Configuration writes take
// effect on the next cycle and are expected only while idle.
module bootload_slave_session_control (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  command,
	input  wire logic [7:0]  sequence_req,
	input  wire logic [63:0] message_uid,
	input  wire logic [1:0]  hex_kind,
	input  wire logic [31:0] read_address,
	input  wire logic [31:0] payload,
	input  wire logic        backend_ok,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ack_valid,
	output logic [2:0]       status,
	output logic [3:0]       action,
	output logic [31:0]      payload_out,
	output logic             announce,
	output logic [2:0]       led_pattern
);
	import bssc_pkg::*;

	msg_t    in_msg;
	msg_t    msg_s1;
	logic    msg_valid_s1;
	logic    space;
	logic    fire;
	cfg_wr_t cfg;
	result_t res_comb;
	result_t res_s2;

	assign in_msg.command      = command;
	assign in_msg.sequence_req = sequence_req;
	assign in_msg.message_uid  = message_uid[UID_WIDTH-1:0];
	assign in_msg.hex_kind     = hex_kind;
	assign in_msg.read_address = read_address;
	assign in_msg.payload      = payload;
	assign in_msg.backend_ok   = backend_ok;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign fire = msg_valid_s1 && space;

	bssc_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_msg       (in_msg),
		.msg_valid_s1 (msg_valid_s1),
		.msg_s1       (msg_s1),
		.take         (space)
	);

	bssc_session u_session (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.msg    (msg_s1),
		.fire   (fire),
		.res    (res_comb)
	);

	bssc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res_in    (res_comb),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign ack_valid   = res_s2.ack_valid;
	assign status      = res_s2.status;
	assign action      = res_s2.action;
	assign payload_out = res_s2.payload_out;
	assign announce    = res_s2.announce;
	assign led_pattern = res_s2.led_pattern;

endmodule
`default_nettype wire

>>> rtl/bssc_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Input stage
// Registers one incoming message transaction and holds it until the session
// logic takes it.
// ----------------------------------------------------------------------------
module bssc_in_stage (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire bssc_pkg::msg_t in_msg,
	output logic              msg_valid_s1,
	output bssc_pkg::msg_t    msg_s1,
	input  wire logic         take
);
	import bssc_pkg::*;

	logic load;

	assign in_ready = !msg_valid_s1 || take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			msg_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			msg_s1 <= in_msg;
		end
	end

endmodule
`default_nettype wire

>>> rtl/bssc_session.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Session logic
// Holds the configuration and session state, checks identifier, selection
// and sequence number, and forms the result of one message.
// ----------------------------------------------------------------------------
module bssc_session (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bssc_pkg::cfg_wr_t cfg,
	input  wire bssc_pkg::msg_t  msg,
	input  wire logic            fire,
	output bssc_pkg::result_t    res
);
	import bssc_pkg::*;

	logic [UID_WIDTH-1:0]  own_uid_q;
	logic                  loading_mode_q;
	logic                  link_ready_q;

	logic                  selected_q;
	logic                  muted_q;
	logic [SEQ_WIDTH-1:0]  last_seq_q;
	logic                  write_ok_q;
	logic [TICK_WIDTH-1:0] tick_q;

	logic                  selected_d;
	logic                  muted_d;
	logic [SEQ_WIDTH-1:0]  last_seq_d;
	logic                  write_ok_d;
	logic [TICK_WIDTH-1:0] tick_d;

	logic                  match;
	logic                  seq_good;
	logic                  gate_pass;
	logic                  ident;
	status_t               res_st;
	logic                  wok_and;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_uid_q      <= '0;
			loading_mode_q <= 1'b0;
			link_ready_q   <= 1'b0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_OWN_UID:      own_uid_q      <= cfg.data[UID_WIDTH-1:0];
				REG_LOADING_MODE: loading_mode_q <= cfg.data[0];
				REG_LINK_READY:   link_ready_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selected_q <= 1'b0;
			muted_q    <= 1'b0;
			last_seq_q <= '0;
			write_ok_q <= 1'b0;
			tick_q     <= '0;
		end else if (fire) begin
			selected_q <= selected_d;
			muted_q    <= muted_d;
			last_seq_q <= last_seq_d;
			write_ok_q <= write_ok_d;
			tick_q     <= tick_d;
		end
	end

	assign match    = (msg.message_uid[UID_WIDTH-1:0] == own_uid_q[UID_WIDTH-1:0]);
	assign seq_good = (msg.sequence_req == SEQ_WIDTH'(last_seq_q + SEQ_STEP));
	assign gate_pass = match && selected_q && seq_good;
	assign res_st   = msg.backend_ok ? ST_OK : ST_ERROR;
	assign wok_and  = write_ok_q && msg.backend_ok;

	always_comb begin
		selected_d      = selected_q;
		muted_d         = muted_q;
		last_seq_d      = last_seq_q;
		write_ok_d      = write_ok_q;
		tick_d          = tick_q;
		ident           = 1'b0;
		res.ack_valid   = 1'b0;
		res.status      = ST_OK;
		res.action      = ACT_NONE;
		res.payload_out = '0;
		res.announce    = 1'b0;

		if (cmd_t'(msg.command) == CMD_TICK) begin
			res.announce = link_ready_q && (tick_q != '0) && !selected_q && !muted_q;
			tick_d       = TICK_WIDTH'(tick_q + 1'b1);
		end else if (link_ready_q) begin
			unique case (cmd_t'(msg.command))
				CMD_HEX_WRITE: begin
					if (selected_q) begin
						res.ack_valid = 1'b1;
						if (!seq_good) begin
							res.status = ST_WRONG_SEQ;
						end else begin
							last_seq_d = msg.sequence_req;
							unique case (hex_kind_t'(msg.hex_kind))
								HEX_BEGIN: begin
									write_ok_d = 1'b1;
									res.action = ACT_HEX_BEGIN;
									res.status = ST_OK;
								end
								HEX_DATA: begin
									write_ok_d = wok_and;
									res.action = ACT_HEX_DATA;
									res.status = wok_and ? ST_OK : ST_ERROR;
								end
								HEX_END: begin
									write_ok_d = wok_and;
									res.action = ACT_HEX_END;
									res.status = wok_and ? ST_OK : ST_ERROR;
								end
								default: res.status = ST_BROKEN;
							endcase
						end
					end
				end
				CMD_IDENTIFY: begin
					if (match && !selected_q) begin
						res.ack_valid = 1'b1;
						ident         = 1'b1;
					end
				end
				CMD_SELECT: begin
					if (match) begin
						last_seq_d    = msg.sequence_req;
						selected_d    = 1'b1;
						muted_d       = 1'b0;
						res.ack_valid = 1'b1;
					end else begin
						selected_d = 1'b0;
						muted_d    = 1'b1;
					end
				end
				CMD_DESELECT: begin
					if (match) begin
						if (selected_q) begin
							res.ack_valid = 1'b1;
							if (seq_good) begin
								last_seq_d = msg.sequence_req;
								selected_d = 1'b0;
							end else begin
								res.status = ST_WRONG_SEQ;
							end
						end
					end else if (selected_q) begin
						res.ack_valid = 1'b1;
						res.status    = ST_WRONG_UID;
					end else begin
						muted_d = 1'b0;
					end
				end
				CMD_HEX_READ, CMD_ERASE_CFG, CMD_ERASE_USER, CMD_ERASE_PROG,
				CMD_CRC, CMD_NAME, CMD_ID, CMD_RESET: begin
					if (match) begin
						res.ack_valid = 1'b1;
						if (!selected_q) begin
							res.status = ST_NOT_SELECTED;
						end else if (!seq_good) begin
							res.status = ST_WRONG_SEQ;
						end
					end else if (selected_q) begin
						res.ack_valid = 1'b1;
						res.status    = ST_WRONG_UID;
					end
					if (gate_pass) begin
						last_seq_d = msg.sequence_req;
						res.status = res_st;
						unique case (cmd_t'(msg.command))
							CMD_HEX_READ: begin
								if (msg.read_address == ADDR_CONTINUE) begin
									res.action = ACT_READ_CONT;
									res.status = ST_OK;
								end else begin
									res.action      = ACT_READ_START;
									res.payload_out = msg.read_address;
								end
							end
							CMD_ERASE_CFG: res.action = ACT_ERASE_CFG;
							CMD_ERASE_USER: begin
								res.action = ACT_ERASE_USER;
								if (msg.backend_ok) write_ok_d = 1'b1;
							end
							CMD_ERASE_PROG: begin
								res.action = ACT_ERASE_PROG;
								if (msg.backend_ok) write_ok_d = 1'b1;
							end
							CMD_CRC: begin
								res.action      = ACT_WRITE_CRC;
								res.payload_out = msg.payload;
							end
							CMD_NAME: begin
								res.action      = ACT_WRITE_NAME;
								res.payload_out = msg.payload;
							end
							CMD_ID: begin
								res.action      = ACT_WRITE_ID;
								res.payload_out = msg.payload & MODULE_ID_MASK;
							end
							default: begin
								res.action = ACT_RESET;
								res.status = ST_OK;
							end
						endcase
					end
				end
				default: ;
			endcase
		end

		if (ident) begin
			res.led_pattern = PAT_IDENT;
		end else if (!link_ready_q) begin
			res.led_pattern = PAT_WAIT;
		end else if (!loading_mode_q) begin
			res.led_pattern = PAT_INIT;
		end else if (selected_d) begin
			res.led_pattern = PAT_SELECT;
		end else if (muted_d) begin
			res.led_pattern = PAT_MUTE;
		end else begin
			res.led_pattern = PAT_LOAD;
		end

		if (!res.ack_valid) begin
			res.status = ST_OK;
		end
	end

endmodule
`default_nettype wire

>>> rtl/bssc_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds one result transaction until it is taken.
// ----------------------------------------------------------------------------
module bssc_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire bssc_pkg::result_t res_in,
	output logic                   space,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bssc_pkg::result_t      res_s2
);
	import bssc_pkg::*;

	assign space = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (space) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_in;
		end
	end

endmodule
`default_nettype wire
